FILE: rtl/core/sida_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the default value width and the ASCII codes that the core emits.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

  // Default width of the signed input value
  localparam int unsigned ValueBitsDefault = 32;

  // ASCII codes
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Threshold and correction for the add-3 step of the binary-to-BCD shift
  localparam logic [3:0] BcdAdjLimit = 4'd5;
  localparam logic [3:0] BcdAdjStep  = 4'd3;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter: top level and sequencer.
// Converts one two's complement value into its decimal text, most significant first.
// Depends on sida_pkg.
// Operation: shift-add-3 conversion of the magnitude, one bit per cycle through a shared
// digit adjust unit, then dropping of leading zeros, an optional minus sign, then one
// character per cycle while the output does not stall; the input stalls until the last
// character is loaded.
// Reset: rst_ni clears the sequencer and the output valid; data registers are not reset.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  // result item channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   character_o,
  output logic                         last_o
);

  // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1); 1233/4096 ~ log10(2)
  localparam int unsigned Digits   = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int unsigned BcdW     = Digits * 4;
  localparam int unsigned BitCntW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DigCntW  = $clog2(Digits + 1);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  state_e               state_q;
  logic                 neg_q;
  logic [VALUE_BITS-1:0] mag_q;
  logic [BcdW-1:0]      bcd_q;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic [DigCntW-1:0]   dig_cnt_q;
  logic                 out_valid_q;
  logic [7:0]           char_q;
  logic                 last_q;

  logic                  in_accept;
  logic                  slot_free;
  logic                  char_load;
  logic [VALUE_BITS-1:0] mag_d;
  logic [BcdW-1:0]       bcd_adj;
  logic [3:0]            top_digit;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign char_load   = slot_free && (state_q == StSign || state_q == StEmit);
  assign top_digit   = bcd_q[BcdW-1 -: 4];

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Form the unsigned magnitude of the incoming value
  assign mag_d = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  // Shared adjust unit: add 3 to every BCD digit of 5 or more
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[i*4 +: 4] >= BcdAdjLimit) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + BcdAdjStep;
      end
    end
  end

  // Sequencer with the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      // drop a character once it is taken and no new one is loaded
      if (out_valid_q && !out_stall_i && !char_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            neg_q     <= value_i[VALUE_BITS-1];
            mag_q     <= mag_d;
            bcd_q     <= '0;
            bit_cnt_q <= BitCntW'(VALUE_BITS);
            state_q   <= StConv;
          end
        end
        StConv: begin
          // advance one magnitude bit into the BCD register
          {bcd_q, mag_q} <= {bcd_adj, mag_q} << 1;
          bit_cnt_q      <= bit_cnt_q - 1'b1;
          if (bit_cnt_q == BitCntW'(1)) begin
            dig_cnt_q <= DigCntW'(Digits);
            state_q   <= StSkip;
          end
        end
        StSkip: begin
          // drop leading zero digits, keeping at least one
          if (top_digit == 4'd0 && dig_cnt_q > DigCntW'(1)) begin
            bcd_q     <= bcd_q << 4;
            dig_cnt_q <= dig_cnt_q - 1'b1;
          end else if (neg_q) begin
            state_q <= StSign;
          end else begin
            state_q <= StEmit;
          end
        end
        StSign: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= CharMinus;
            last_q      <= 1'b0;
            state_q     <= StEmit;
          end
        end
        StEmit: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= CharZero + {4'd0, top_digit};
            last_q      <= (dig_cnt_q == DigCntW'(1));
            bcd_q       <= bcd_q << 4;
            dig_cnt_q   <= dig_cnt_q - 1'b1;
            if (dig_cnt_q == DigCntW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Every character shown is a minus sign or a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CharMinus) ||
                    ((character_o >= CharZero) && (character_o <= CharNine)))
    else $error("character out of range");

  // The final character of an item is always a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (character_o != CharMinus))
    else $error("minus sign flagged as last");

  // An accepted item starts the bit conversion with a full count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == StConv) && (bit_cnt_q == BitCntW'(VALUE_BITS)))
    else $error("conversion did not start");

  // A digit count of zero never reaches the skip or emit stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit || state_q == StSkip) |-> (dig_cnt_q != '0))
    else $error("digit count underflow");

endmodule

FILE: tb/tb.sv
// Testbench for signed_int_to_decimal_ascii: drives signed values and checks the ASCII
// characters and last flags against a built-in decimal text predictor.
// Depends on sida_pkg and the signed_int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb;
  import sida_pkg::*;

  localparam int unsigned       ValueBits  = ValueBitsDefault;
  localparam logic [ValueBits-1:0] Radix   = 10;
  localparam int                MaxReports = 10;
  localparam int                RandItems  = 350;
  localparam int                Phases     = 4;
  localparam int                TailCycles = 60;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Holds the characters still owed by the block and counts failures
  class decimal_text_checker;
    text_char_t owed_chars[$];
    int         failures;

    function new();
      failures = 0;
    endfunction

    // Spell an accepted value in decimal and queue its characters
    function void add_value(logic [ValueBits-1:0] value);
      logic [ValueBits-1:0] mag;
      logic [7:0]           digits[$];
      text_char_t           tc;
      mag = value[ValueBits-1] ? (~value + 1'b1) : value;
      do begin
        digits.push_front(CharZero + 8'(mag % Radix));
        mag = mag / Radix;
      end while (mag != 0);
      if (value[ValueBits-1]) begin
        tc.code = CharMinus;
        tc.last = 1'b0;
        owed_chars.push_back(tc);
      end
      foreach (digits[i]) begin
        tc.code = digits[i];
        tc.last = (i == digits.size() - 1);
        owed_chars.push_back(tc);
      end
    endfunction

    // Compare one accepted character with the oldest owed one
    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("%0t: unexpected character 0x%02h last %0b", $realtime, code, last);
        return;
      end
      want = owed_chars.pop_front();
      if (code !== want.code || last !== want.last) begin
        failures++;
        if (failures <= MaxReports)
          $display("%0t: mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                   $realtime, want.code, want.last, code, last);
      end
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [ValueBits-1:0] value_i     = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [7:0]                  character_o;
  logic                        last_o;

  decimal_text_checker board = new();
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int hold_request       = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(ValueBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard limit on run time
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receive characters, stall at random or for a requested long stretch
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_char(character_o, last_o);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Offer one value, idle first at random, and note it once accepted
  task automatic send_value(input logic [ValueBits-1:0] value);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < sender_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    board.add_value(value);
  endtask

  // Drop valid and hold until every owed character has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk_i);
  endtask

  // Mix full-range values, small values, values near powers of ten and values of a random digit count
  function automatic logic [ValueBits-1:0] random_value();
    logic [ValueBits-1:0] mag;
    int unsigned          scale;
    int                   k;
    k     = $urandom_range(9);
    scale = 1;
    for (int i = 0; i < k; i++)
      scale = scale * 10;
    case ($urandom_range(3))
      0:       return $urandom();
      1:       mag = $urandom_range(20);
      2:       mag = scale + $urandom_range(2) - 1;
      default: mag = $urandom_range(scale - 1, scale / 10);
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    logic [ValueBits-1:0] corner_values[$];
    corner_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1_000_000_000,
                      32'd999_999_999, -32'sd999_999_999, 32'd123_456_789, -32'sd5,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'd4_294_967_286, 32'd1_234_567_890};

    // Hold reset, then release it
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner values with no idling
    foreach (corner_values[i])
      send_value(corner_values[i]);
    wait_drained();

    // Random values over several idling mixes
    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
        default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
      endcase
      // Back up the block with a long receiver hold while values keep coming
      if (phase == 1) begin
        sender_idle_pct = 0;
        hold_request    = 400;
        repeat (15) send_value(random_value());
        wait_drained();
        sender_idle_pct = 73;
      end
      repeat (RandItems / Phases) send_value(random_value());
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sida_pkg.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/tb.sv
